/* rtl/ptb_pkg.sv */
// Shared types and constants for the periodic timer bank.
package ptb_pkg;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_REGISTER = 2'd1;
	localparam logic [1:0] OP_CHECK    = 2'd2;

	localparam logic [31:0] US_PER_TICK = 32'd1000;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] period;
	} req_t;

	typedef struct packed {
		logic [2:0]  slot;
		logic        alloc_error;
		logic [7:0]  fired_mask;
		logic [31:0] ms_count;
		logic [31:0] us_base;
	} rsp_t;

	// Per-item result fields produced by the sequencer.
	typedef struct packed {
		logic [2:0] slot;
		logic       alloc_error;
		logic [7:0] fired_mask;
	} res_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	typedef struct packed {
		logic        en_period;
		logic        en_count;
		logic [31:0] period;
		logic [31:0] count;
	} store_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_SCAN,
		ST_FINISH
	} seq_state_t;

endpackage

/* rtl/ptb_store.sv */
// Period and countdown storage for all timer slots, one write and one registered read port.
module ptb_store #(
	parameter int NUM_TIMERS = 8,
	parameter int IDX_W      = 3
) (
	input  logic               clk,
	input  ptb_pkg::store_wr_t wr,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [31:0]        rd_period,
	output logic [31:0]        rd_count
);

	logic [31:0] period_mem [NUM_TIMERS];
	logic [31:0] count_mem  [NUM_TIMERS];

	always_ff @(posedge clk) begin
		if (wr.en_period) begin
			period_mem[wr_addr] <= wr.period;
		end
		if (wr.en_count) begin
			count_mem[wr_addr] <= wr.count;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_period <= period_mem[rd_addr];
			rd_count  <= count_mem[rd_addr];
		end
	end

endmodule

/* rtl/ptb_seq.sv */
// Slot sequencer: walks the timer slots through one shared decrementer.
module ptb_seq #(
	parameter int NUM_TIMERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  ptb_pkg::req_t        req,
	input  logic                 ack,
	output ptb_pkg::seq_status_t status,
	output ptb_pkg::res_t        res
);

	localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
	localparam int MASK_N = (NUM_TIMERS < 8) ? NUM_TIMERS : 8;

	ptb_pkg::seq_state_t state_q, state_d;

	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      cnt_idx;
	logic                  cnt_lt_n;
	logic                  pvld_s1;
	logic [IDX_W-1:0]      pidx_s1;
	logic [NUM_TIMERS-1:0] en_q;
	logic [NUM_TIMERS-1:0] trig_q;
	logic [31:0]           per_q;
	ptb_pkg::res_t         res_q;

	logic                  rd_en;
	logic [31:0]           rd_period;
	logic [31:0]           rd_count;
	ptb_pkg::store_wr_t    wr;
	logic [IDX_W-1:0]      wr_addr;
	logic [31:0]           dec_op;
	logic [31:0]           dec_res;
	logic                  set_trig;
	logic                  found;
	logic [7:0]            mask;

	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign cnt_lt_n = (cnt_q < CNT_W'(NUM_TIMERS));
	assign mask     = 8'(trig_q[MASK_N-1:0]);

	// The one arithmetic unit: every reload and countdown step goes through here.
	assign dec_res = dec_op - 32'd1;

	ptb_store #(
		.NUM_TIMERS(NUM_TIMERS),
		.IDX_W     (IDX_W)
	) u_store (
		.clk      (clk),
		.wr       (wr),
		.wr_addr  (wr_addr),
		.rd_en    (rd_en),
		.rd_addr  (cnt_idx),
		.rd_period(rd_period),
		.rd_count (rd_count)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptb_pkg::ST_IDLE: begin
				if (start) begin
					unique case (req.op)
						ptb_pkg::OP_TICK: state_d = ptb_pkg::ST_TICK;
						ptb_pkg::OP_REGISTER: begin
							state_d = (req.period == 32'd0) ? ptb_pkg::ST_FINISH
							                                : ptb_pkg::ST_SCAN;
						end
						default: state_d = ptb_pkg::ST_FINISH;
					endcase
				end
			end
			ptb_pkg::ST_TICK: begin
				if (!cnt_lt_n && !pvld_s1) begin
					state_d = ptb_pkg::ST_FINISH;
				end
			end
			ptb_pkg::ST_SCAN: begin
				if (found || !cnt_lt_n) begin
					state_d = ptb_pkg::ST_FINISH;
				end
			end
			ptb_pkg::ST_FINISH: begin
				if (ack) begin
					state_d = ptb_pkg::ST_IDLE;
				end
			end
			default: state_d = ptb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		wr       = '0;
		wr_addr  = pidx_s1;
		dec_op   = per_q;
		set_trig = 1'b0;
		found    = 1'b0;
		unique case (state_q)
			ptb_pkg::ST_TICK: begin
				rd_en = cnt_lt_n;
				// Slot read last cycle is updated now while the next one is read.
				if (pvld_s1 && en_q[pidx_s1]) begin
					dec_op      = (rd_count != 32'd0) ? rd_count : rd_period;
					wr.en_count = 1'b1;
					wr.count    = dec_res;
					set_trig    = (rd_count == 32'd0);
				end
			end
			ptb_pkg::ST_SCAN: begin
				wr_addr = cnt_idx;
				if (cnt_lt_n && !en_q[cnt_idx]) begin
					found        = 1'b1;
					wr.en_period = 1'b1;
					wr.en_count  = 1'b1;
					wr.period    = per_q;
					wr.count     = dec_res;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptb_pkg::ST_IDLE;
			cnt_q   <= '0;
			pvld_s1 <= 1'b0;
			en_q    <= '0;
			trig_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ptb_pkg::ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						pvld_s1 <= 1'b0;
						if (req.op == ptb_pkg::OP_CHECK) begin
							trig_q <= '0;
						end
					end
				end
				ptb_pkg::ST_TICK: begin
					if (cnt_lt_n) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					pvld_s1 <= rd_en;
					if (set_trig) begin
						trig_q[pidx_s1] <= 1'b1;
					end
				end
				ptb_pkg::ST_SCAN: begin
					if (found) begin
						en_q[cnt_idx]   <= 1'b1;
						trig_q[cnt_idx] <= 1'b0;
					end else if (cnt_lt_n) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ptb_pkg::ST_TICK) begin
			pidx_s1 <= cnt_idx;
		end
		if (state_q == ptb_pkg::ST_IDLE && start) begin
			per_q <= req.period;
			res_q <= '{slot:        3'd0,
			           alloc_error: (req.op == ptb_pkg::OP_REGISTER && req.period == 32'd0),
			           fired_mask:  (req.op == ptb_pkg::OP_CHECK) ? mask : 8'd0};
		end
		if (state_q == ptb_pkg::ST_SCAN) begin
			if (found) begin
				res_q.slot <= 3'(cnt_q);
			end else if (!cnt_lt_n) begin
				res_q.alloc_error <= 1'b1;
			end
		end
	end

	assign status.idle = (state_q == ptb_pkg::ST_IDLE);
	assign status.done = (state_q == ptb_pkg::ST_FINISH);
	assign res         = res_q;

	// A slot can only have fired if it has been registered.
	a_trig_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		(trig_q & ~en_q) == '0)
		else $error("triggered flag set on a free slot");

	// Timers are never released once registered.
	a_en_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (en_q & $past(en_q)) == $past(en_q))
		else $error("enabled slot was cleared");

	// The slot walk never runs past the last slot.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_TIMERS))
		else $error("slot counter out of range");

	// A successful register leaves the error flag clear.
	a_found_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		found |=> !res_q.alloc_error && state_q == ptb_pkg::ST_FINISH)
		else $error("allocation reported as failed");

endmodule

/* rtl/periodic_timer_bank.sv */
// Periodic timer bank top level: request/response channels, boot counters and output register.
//
// Requests arrive on req (req_valid/req_ready); each carries an op and a period.
// A tick advances ms_count by one and us_base by 1000 and steps every registered
// timer; a register takes the lowest free slot; a check returns and clears the
// triggered mask. Every request produces exactly one response on rsp
// (rsp_valid/rsp_ready), which also carries the counts after the request.
// The block handles one request at a time. A tick walks the slots through one
// shared decrementer, one slot per cycle with the slot store read a cycle ahead.
// A register scans the enable bits one slot per cycle and stops at the lowest free
// slot, or after the last slot when the table is full; a zero period skips the scan.
// A check or an unknown op goes straight to the finish state. req_ready returns
// as the response is loaded into the output register; a waiting response does not
// hold off the next request. If the receiver stalls with a response still held, a
// finished request waits until the output register frees up.
// Reset clears all enables, triggered flags and both counters; period entries are
// written only when a slot is registered, countdown entries also on every tick.
module periodic_timer_bank #(
	parameter int NUM_TIMERS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ptb_pkg::rsp_t rsp
);

	ptb_pkg::seq_status_t status;
	ptb_pkg::res_t        res;
	logic                 start;
	logic                 ack;
	logic [31:0]          ms_q;
	logic [31:0]          us_q;
	logic                 rsp_valid_q;
	ptb_pkg::rsp_t        rsp_q;

	assign req_ready = status.idle;
	assign start     = req_valid && req_ready;
	assign ack       = !rsp_valid_q || rsp_ready;

	ptb_seq #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.ack   (ack),
		.status(status),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q        <= '0;
			us_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (start && req.op == ptb_pkg::OP_TICK) begin
				ms_q <= ms_q + 32'd1;
				us_q <= us_q + ptb_pkg::US_PER_TICK;
			end
			if (status.done && ack) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (status.done && ack) begin
			rsp_q.slot        <= res.slot;
			rsp_q.alloc_error <= res.alloc_error;
			rsp_q.fired_mask  <= res.fired_mask;
			rsp_q.ms_count    <= ms_q;
			rsp_q.us_base     <= us_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Once a request is taken, req_ready is low in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !req_ready)
		else $error("request accepted while busy");

	// Only ticks move the millisecond count.
	a_ms_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && req.op == ptb_pkg::OP_TICK) |=> ms_q == $past(ms_q))
		else $error("millisecond count moved without a tick");

	// The two counters move together.
	a_us_tracks_ms: assert property (@(posedge clk) disable iff (!arst_n)
		start && req.op == ptb_pkg::OP_TICK |=> us_q == $past(us_q) + ptb_pkg::US_PER_TICK)
		else $error("microsecond base out of step");

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the periodic timer bank: directed and random handshake traffic against a predictor.
`timescale 1ns / 100ps

module tb_top;

	localparam int          NSLOT       = 8;
	localparam logic [1:0]  OP_UNUSED   = 2'd3;
	localparam int          RAND_ITEMS  = 800;
	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		ptb_pkg::req_t item;
		bit            drain;
	} pending_t;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	ptb_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	ptb_pkg::rsp_t  rsp;

	pending_t       pending_q[$];
	ptb_pkg::rsp_t  outcome_q[$];
	int             err_cnt      = 0;
	int             accepted_cnt = 0;
	int             total_items  = 1;
	int unsigned    cycle_cnt    = 0;

	// Predictor state of the timer bank.
	logic [31:0]      slot_period [NSLOT];
	logic [31:0]      slot_count  [NSLOT];
	logic [NSLOT-1:0] slot_en    = '0;
	logic [NSLOT-1:0] slot_fired = '0;
	logic [31:0]      bank_ms    = '0;
	logic [31:0]      bank_us    = '0;

	periodic_timer_bank #(.NUM_TIMERS(NSLOT)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic ptb_pkg::rsp_t step_timer_bank(ptb_pkg::req_t r);
		ptb_pkg::rsp_t o;
		bit            placed;
		o = '0;
		placed = 1'b0;
		case (r.op)
			ptb_pkg::OP_TICK: begin
				bank_ms = bank_ms + 32'd1;
				bank_us = bank_us + ptb_pkg::US_PER_TICK;
				for (int i = 0; i < NSLOT; i++) begin
					if (slot_en[i]) begin
						if (slot_count[i] != 32'd0) begin
							slot_count[i] = slot_count[i] - 32'd1;
						end else begin
							slot_count[i] = slot_period[i] - 32'd1;
							slot_fired[i] = 1'b1;
						end
					end
				end
			end
			ptb_pkg::OP_REGISTER: begin
				if (r.period != 32'd0) begin
					for (int i = 0; i < NSLOT; i++) begin
						if (!placed && !slot_en[i]) begin
							placed         = 1'b1;
							slot_period[i] = r.period;
							slot_count[i]  = r.period - 32'd1;
							slot_en[i]     = 1'b1;
							slot_fired[i]  = 1'b0;
							o.slot         = 3'(i);
						end
					end
				end
				o.alloc_error = !placed;
			end
			ptb_pkg::OP_CHECK: begin
				o.fired_mask = slot_fired[7:0];
				slot_fired   = '0;
			end
			default: begin
			end
		endcase
		o.ms_count = bank_ms;
		o.us_base  = bank_us;
		return o;
	endfunction

	task automatic flag_mismatch(string what);
		$display("MISMATCH at cycle %0d: %s", cycle_cnt, what);
		err_cnt++;
	endtask

	function automatic int phase_of();
		if (accepted_cnt < total_items / 3) return 0;
		if (accepted_cnt < (2 * total_items) / 3) return 1;
		return 2;
	endfunction

	function automatic int send_idle_pct();
		case (phase_of())
			0: return 23;
			1: return 68;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (phase_of())
			0: return 68;
			1: return 23;
			default: return 0;
		endcase
	endfunction

	task automatic queue_request(logic [1:0] op, logic [31:0] period, bit drain = 1'b0);
		pending_t p;
		p.item.op     = op;
		p.item.period = period;
		p.drain       = drain;
		pending_q.push_back(p);
	endtask

	function automatic logic [31:0] pick_period();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) return 32'($urandom_range(1, 12));
		if (sel < 75) return 32'd0;
		if (sel < 90) return 32'($urandom);
		return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
	endfunction

	// Request driver: presents queued requests and records the expected response on acceptance.
	always @(posedge clk or negedge arst_n) begin
		pending_t nxt;
		bit       take;
		bit       advance;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			advance = !req_valid;
			if (req_valid && req_ready) begin
				outcome_q.push_back(step_timer_bank(req));
				accepted_cnt++;
				advance = 1'b1;
			end
			if (advance) begin
				take = 1'b0;
				if (pending_q.size() != 0) begin
					nxt = pending_q[0];
					// A drain request holds back until every outstanding response is in.
					if (nxt.drain && outcome_q.size() != 0)
						take = 1'b0;
					else
						take = ($urandom_range(0, 99) >= send_idle_pct());
				end
				if (take) begin
					void'(pending_q.pop_front());
					req_valid <= 1'b1;
					req       <= nxt.item;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compares each accepted response with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		ptb_pkg::rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					flag_mismatch("response with no request outstanding");
				end else begin
					want = outcome_q.pop_front();
					if (rsp.slot !== want.slot)
						flag_mismatch($sformatf("slot got %0d want %0d", rsp.slot, want.slot));
					if (rsp.alloc_error !== want.alloc_error)
						flag_mismatch($sformatf("alloc_error got %0b want %0b",
							rsp.alloc_error, want.alloc_error));
					if (rsp.fired_mask !== want.fired_mask)
						flag_mismatch($sformatf("fired_mask got %h want %h",
							rsp.fired_mask, want.fired_mask));
					if (rsp.ms_count !== want.ms_count)
						flag_mismatch($sformatf("ms_count got %0d want %0d",
							rsp.ms_count, want.ms_count));
					if (rsp.us_base !== want.us_base)
						flag_mismatch($sformatf("us_base got %0d want %0d",
							rsp.us_base, want.us_base));
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned sel;
		logic [1:0]  op;

		// Directed part: empty check, ignored op, zero period, ticks and checks, allocation past a full table.
		queue_request(ptb_pkg::OP_CHECK, 32'd0);
		queue_request(OP_UNUSED, 32'hFFFF_FFFF);
		queue_request(ptb_pkg::OP_REGISTER, 32'd0);
		queue_request(ptb_pkg::OP_REGISTER, 32'd1);
		queue_request(ptb_pkg::OP_REGISTER, 32'hFFFF_FFFF);
		queue_request(ptb_pkg::OP_TICK, 32'd0);
		queue_request(ptb_pkg::OP_TICK, 32'hFFFF_FFFF);
		queue_request(ptb_pkg::OP_CHECK, 32'd0);
		queue_request(ptb_pkg::OP_REGISTER, 32'd2);
		queue_request(ptb_pkg::OP_REGISTER, 32'd3);
		queue_request(ptb_pkg::OP_REGISTER, 32'd5);
		queue_request(ptb_pkg::OP_REGISTER, 32'd8);
		queue_request(ptb_pkg::OP_REGISTER, 32'd13);
		queue_request(ptb_pkg::OP_REGISTER, 32'h8000_0000);
		queue_request(ptb_pkg::OP_REGISTER, 32'd7);
		queue_request(ptb_pkg::OP_TICK, 32'd0);
		queue_request(ptb_pkg::OP_TICK, 32'd0);
		queue_request(ptb_pkg::OP_TICK, 32'd0);
		queue_request(ptb_pkg::OP_CHECK, 32'd0);
		queue_request(ptb_pkg::OP_CHECK, 32'd0);
		queue_request(OP_UNUSED, 32'd0, 1'b1);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) op = ptb_pkg::OP_TICK;
			else if (sel < 67) op = ptb_pkg::OP_REGISTER;
			else if (sel < 92) op = ptb_pkg::OP_CHECK;
			else op = OP_UNUSED;
			queue_request(op, (op == ptb_pkg::OP_REGISTER) ? pick_period() : 32'($urandom),
				(n == RAND_ITEMS / 3) || (n == (2 * RAND_ITEMS) / 3));
		end
		total_items = pending_q.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || req_valid) @(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (NSLOT + 10) @(posedge clk);

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
